// File: rtl/wsr_pkg.sv
`timescale 1ns / 1ps
package wsr_pkg;
  localparam int unsigned NbrBits  = 4;
  localparam int unsigned DstBits  = 6;
  localparam int unsigned CostBits = 16;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned Nbrs     = 1 << NbrBits;
  localparam int unsigned Dsts     = 1 << DstBits;
  localparam int unsigned Routes   = Nbrs * Dsts;
  localparam int unsigned RtBits   = NbrBits + DstBits;

  localparam logic OpLoad = 1'b0;
  localparam logic OpAdv  = 1'b1;

  localparam logic [1:0] StChanged   = 2'd0;
  localparam logic [1:0] StUnchanged = 2'd1;
  localparam logic [1:0] StNoLink    = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [NbrBits-1:0]  neighbor;
    logic [DstBits-1:0]  destination;
    logic [CostBits-1:0] path_length;
    logic [CostBits-1:0] path_width;
    logic [CostBits-1:0] link_length;
    logic [CostBits-1:0] link_width;
    logic [TimeBits-1:0] event_time;
  } item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [DstBits-1:0]  route_destination;
    logic [CostBits-1:0] best_width;
    logic [CostBits-1:0] best_length;
    logic [NbrBits-1:0]  best_next_hop;
    logic [TimeBits-1:0] stable_time;
  } result_t;
endpackage

// File: rtl/widest_shortest_route_update.sv
`timescale 1ns / 1ps
// Route update engine for one router.
// A transaction is started by holding start_i high with the item on item_i
// while busy_o is low. Load transactions store a neighbor's link width and
// length; advertisement transactions update the forwarding entry of the
// advertised destination. Each transaction gives exactly one result on
// result_o, marked by a one-cycle pulse on done_o; the receiver cannot
// stall it. mode_we_i/mode_i write the mode register; the user must do so
// only while idle, as the block itself does not enforce it. A load or any
// advertisement without a fallback passes the read, decide and result
// states after acceptance; busy_o drops in the cycle after the result, and
// only then is a new transaction accepted. When the current next hop
// re-advertises at equal width and no shorter length in mode 1, a fallback
// scan walks the destination's 16 remembered routes through the one read
// port of the route memory, one per cycle; its result follows the scan.
// The forwarding and route memories are arrays read with registered data.
// Route valid bits live in the route memory: after reset a clearing pass
// writes all 1024 entries, one per cycle, with busy_o high throughout.
// After reset the mode is 0 and the creation counter is zero.
module widest_shortest_route_update (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  wsr_pkg::item_t   item_i,
  output logic             busy_o,
  input  logic             mode_we_i,
  input  logic             mode_i,
  output logic             done_o,
  output wsr_pkg::result_t result_o
);
  localparam int unsigned NB = wsr_pkg::NbrBits;
  localparam int unsigned DB = wsr_pkg::DstBits;
  localparam int unsigned CB = wsr_pkg::CostBits;
  localparam int unsigned TB = wsr_pkg::TimeBits;
  localparam int unsigned RB = wsr_pkg::RtBits;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_SCAN, S_SCANLAST, S_DONE
  } state_e;

  typedef struct packed {
    logic [CB-1:0] w;
    logic [CB-1:0] l;
    logic [NB-1:0] nh;
    logic [TB-1:0] t;
  } fwd_t;

  typedef struct packed {
    logic          v;
    logic [CB-1:0] w;
    logic [CB-1:0] l;
    logic [15:0]   ord;
  } rt_t;

  // Stores.
  logic [wsr_pkg::Nbrs-1:0]   link_present_q;
  logic [CB-1:0]              link_w_q [wsr_pkg::Nbrs];
  logic [CB-1:0]              link_l_q [wsr_pkg::Nbrs];
  logic [wsr_pkg::Dsts-1:0]   fwd_valid_q;
  fwd_t                       fwd_mem [wsr_pkg::Dsts];
  rt_t                        rt_mem [wsr_pkg::Routes];
  logic [15:0]                creation_q;
  logic                       mode_q;

  state_e          state_q;
  logic [RB-1:0]   clr_q;
  wsr_pkg::item_t  item_q;
  fwd_t            fwd_rd_q;
  rt_t             rt_rd_q;
  logic            rt_rd_valid_q;
  logic [NB-1:0]   scan_q;
  logic [NB-1:0]   scan_prev_q;
  logic            found_q;
  logic [NB-1:0]   best_q;
  rt_t             best_rt_q;
  fwd_t            cur_q;
  logic            cur_valid_q;
  logic [1:0]      status_q;
  logic            done_q;
  logic [CB-1:0]   pw_q;
  logic [CB-1:0]   pl_q;

  // Path width and saturated path length for the current item.
  logic [CB-1:0] lw, ll, pw;
  logic [CB:0]   lsum;
  logic [CB-1:0] pl;
  assign lw   = link_w_q[item_q.neighbor];
  assign ll   = link_l_q[item_q.neighbor];
  assign pw   = (lw < item_q.path_width) ? lw : item_q.path_width;
  assign lsum = {1'b0, item_q.path_length} + {1'b0, ll};
  assign pl   = lsum[CB] ? {CB{1'b1}} : lsum[CB-1:0];

  logic [RB-1:0] ridx, sidx;
  assign ridx = {item_q.destination, item_q.neighbor};
  assign sidx = {item_q.destination, scan_q};

  // Memory write and read ports.
  logic          fwd_we;
  fwd_t          fwd_wd;
  logic          rt_we;
  logic [RB-1:0] rt_wa;
  rt_t           rt_wd;
  logic          rt_rd_en;
  logic [RB-1:0] rt_ra;

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[item_q.destination] <= fwd_wd;
    end
    fwd_rd_q <= fwd_mem[item_q.destination];
    if (rt_we) begin
      rt_mem[rt_wa] <= rt_wd;
    end
    if (rt_rd_en) begin
      rt_rd_q <= rt_mem[rt_ra];
    end
    if (start_i && !busy_o) begin
      item_q <= item_i;
    end
    if (state_q == S_READ) begin
      pw_q <= pw;
      pl_q <= pl;
    end
  end

  // Decision logic for the DECIDE state.
  logic          link_ok;
  logic          in_valid;
  logic          fb_start;
  fwd_t          dec_fwd;
  logic          dec_fwd_we;
  logic          dec_rt_we;
  rt_t           dec_rt;
  logic          dec_new_route;
  logic [1:0]    dec_status;

  assign link_ok  = link_present_q[item_q.neighbor];
  assign in_valid = fwd_valid_q[item_q.destination];

  always_comb begin
    dec_fwd       = fwd_rd_q;
    dec_fwd_we    = 1'b0;
    dec_rt_we     = 1'b0;
    dec_new_route = !rt_rd_q.v;
    dec_rt        = rt_rd_q;
    dec_status    = wsr_pkg::StUnchanged;
    fb_start      = 1'b0;
    if (dec_new_route) begin
      dec_rt.w   = pw_q;
      dec_rt.ord = creation_q;
    end
    dec_rt.v = 1'b1;
    dec_rt.l = pl_q;
    if (item_q.operation == wsr_pkg::OpLoad) begin
      dec_status = wsr_pkg::StUnchanged;
    end else if (!link_ok) begin
      dec_status = wsr_pkg::StNoLink;
    end else if (!in_valid) begin
      dec_fwd    = '{w: pw_q, l: pl_q, nh: item_q.neighbor, t: item_q.event_time};
      dec_fwd_we = 1'b1;
      dec_rt_we  = mode_q;
      dec_status = wsr_pkg::StChanged;
    end else if (!mode_q) begin
      if (fwd_rd_q.l > pl_q || (fwd_rd_q.l == pl_q && fwd_rd_q.w < pw_q)) begin
        dec_fwd    = '{w: pw_q, l: pl_q, nh: item_q.neighbor, t: item_q.event_time};
        dec_fwd_we = 1'b1;
        dec_status = wsr_pkg::StChanged;
      end
    end else if (fwd_rd_q.w < pw_q) begin
      dec_fwd    = '{w: pw_q, l: pl_q, nh: item_q.neighbor, t: item_q.event_time};
      dec_fwd_we = 1'b1;
      dec_rt_we  = 1'b1;
      dec_status = wsr_pkg::StChanged;
    end else if (fwd_rd_q.w == pw_q) begin
      dec_rt_we = 1'b1;
      if (fwd_rd_q.l > pl_q) begin
        dec_fwd.l  = pl_q;
        dec_fwd.nh = item_q.neighbor;
        dec_fwd.t  = item_q.event_time;
        dec_fwd_we = 1'b1;
        dec_status = wsr_pkg::StChanged;
      end else if (fwd_rd_q.nh == item_q.neighbor) begin
        dec_fwd.l  = pl_q;
        dec_fwd.t  = item_q.event_time;
        dec_fwd_we = 1'b1;
        dec_status = wsr_pkg::StChanged;
        fb_start   = 1'b1;
      end
    end
  end

  // Scan compare: the one shared compare unit, fed one stored route per cycle.
  // rt_rd_valid_q marks read data that belongs to the scan.
  logic          qual;
  assign qual = rt_rd_valid_q && rt_rd_q.v && rt_rd_q.w >= cur_q.w && rt_rd_q.l < cur_q.l &&
                (!found_q || rt_rd_q.ord < best_rt_q.ord);

  always_comb begin
    fwd_we   = 1'b0;
    fwd_wd   = dec_fwd;
    rt_we    = 1'b0;
    rt_wa    = ridx;
    rt_wd    = dec_rt;
    rt_rd_en = 1'b0;
    rt_ra    = ridx;
    unique case (state_q)
      S_CLEAR: begin
        rt_we = 1'b1;
        rt_wa = clr_q;
        rt_wd = '0;
      end
      S_IDLE: begin
        rt_rd_en = 1'b0;
      end
      S_READ: begin
        rt_rd_en = 1'b1;
      end
      S_DECIDE: begin
        fwd_we = dec_fwd_we && item_q.operation == wsr_pkg::OpAdv;
        rt_we  = dec_rt_we && link_ok && item_q.operation == wsr_pkg::OpAdv;
      end
      S_SCAN, S_SCANLAST: begin
        rt_rd_en = (state_q == S_SCAN);
        rt_ra    = sidx;
        if (state_q == S_SCANLAST) begin
          fwd_we = 1'b1;
          fwd_wd = cur_q;
          if (found_q || qual) begin
            fwd_wd.w  = qual ? rt_rd_q.w : best_rt_q.w;
            fwd_wd.l  = qual ? rt_rd_q.l : best_rt_q.l;
            fwd_wd.nh = qual ? scan_prev_q : best_q;
          end
        end
      end
      S_DONE: begin
        rt_rd_en = 1'b0;
      end
      default: begin
        rt_rd_en = 1'b0;
      end
    endcase
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;

  always_comb begin
    result_o.status            = status_q;
    result_o.route_destination = item_q.destination;
    result_o.best_width        = cur_valid_q ? cur_q.w : '0;
    result_o.best_length       = cur_valid_q ? cur_q.l : '0;
    result_o.best_next_hop     = cur_valid_q ? cur_q.nh : '0;
    result_o.stable_time       = cur_valid_q ? cur_q.t : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      link_present_q <= '0;
      fwd_valid_q    <= '0;
      creation_q     <= '0;
      mode_q         <= 1'b0;
      done_q         <= 1'b0;
      status_q       <= wsr_pkg::StUnchanged;
      cur_valid_q    <= 1'b0;
      cur_q          <= '0;
      scan_q         <= '0;
      scan_prev_q    <= '0;
      found_q        <= 1'b0;
      best_q         <= '0;
      best_rt_q      <= '0;
      rt_rd_valid_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (mode_we_i) begin
        mode_q <= mode_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == {RB{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          status_q    <= dec_status;
          cur_q       <= dec_fwd;
          cur_valid_q <= in_valid || dec_fwd_we;
          if (item_q.operation == wsr_pkg::OpLoad) begin
            link_present_q[item_q.neighbor] <= 1'b1;
            link_w_q[item_q.neighbor]       <= item_q.link_width;
            link_l_q[item_q.neighbor]       <= item_q.link_length;
          end
          if (dec_fwd_we && item_q.operation == wsr_pkg::OpAdv) begin
            fwd_valid_q[item_q.destination] <= 1'b1;
          end
          if (dec_rt_we && link_ok && item_q.operation == wsr_pkg::OpAdv) begin
            if (dec_new_route) begin
              creation_q <= creation_q + 16'd1;
            end
          end
          if (fb_start) begin
            state_q <= S_SCAN;
            scan_q  <= '0;
            found_q <= 1'b0;
            rt_rd_valid_q <= 1'b0;
          end else begin
            state_q <= S_DONE;
            done_q  <= 1'b1;
          end
        end
        S_SCAN: begin
          // Read address scan_q now; compare the route read last cycle.
          if (qual) begin
            found_q   <= 1'b1;
            best_q    <= scan_prev_q;
            best_rt_q <= rt_rd_q;
          end
          rt_rd_valid_q <= 1'b1;
          scan_prev_q   <= scan_q;
          scan_q        <= scan_q + 1'b1;
          if (scan_q == {NB{1'b1}}) begin
            state_q <= S_SCANLAST;
          end
        end
        S_SCANLAST: begin
          if (qual) begin
            cur_q.w  <= rt_rd_q.w;
            cur_q.l  <= rt_rd_q.l;
            cur_q.nh <= scan_prev_q;
          end else if (found_q) begin
            cur_q.w  <= best_rt_q.w;
            cur_q.l  <= best_rt_q.l;
            cur_q.nh <= best_q;
          end
          state_q <= S_DONE;
          done_q  <= 1'b1;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// File: tb/sv/widest_shortest_route_update_tb.sv
`timescale 1ns / 1ps
module widest_shortest_route_update_tb;

  // Mirror of the route engine's tables. Every update computes the forwarding
  // entry that the block should report for one transaction, and a queue holds
  // the entries still owed by the block.
  class route_table_tracker;
    logic              cur_mode;
    bit                link_ok [wsr_pkg::Nbrs];
    logic [15:0]       link_w [wsr_pkg::Nbrs];
    logic [15:0]       link_l [wsr_pkg::Nbrs];
    bit                fwd_ok [wsr_pkg::Dsts];
    logic [15:0]       fwd_w [wsr_pkg::Dsts];
    logic [15:0]       fwd_l [wsr_pkg::Dsts];
    logic [3:0]        fwd_hop [wsr_pkg::Dsts];
    logic [31:0]       fwd_t [wsr_pkg::Dsts];
    bit                rt_ok [wsr_pkg::Routes];
    logic [15:0]       rt_w [wsr_pkg::Routes];
    logic [15:0]       rt_l [wsr_pkg::Routes];
    logic [15:0]       rt_ord [wsr_pkg::Routes];
    logic [15:0]       birth_count;
    wsr_pkg::result_t  owed_results[$];
    int                failures;

    function new();
      cur_mode = 1'b0;
      birth_count = '0;
      failures = 0;
      foreach (link_ok[i]) link_ok[i] = 0;
      foreach (fwd_ok[i]) fwd_ok[i] = 0;
      foreach (rt_ok[i]) rt_ok[i] = 0;
    endfunction

    // A remembered route keeps its width once created; only its length moves.
    function void remember(int idx, logic [15:0] w, logic [15:0] l);
      if (!rt_ok[idx]) begin
        rt_ok[idx] = 1;
        rt_w[idx] = w;
        rt_l[idx] = l;
        rt_ord[idx] = birth_count;
        birth_count = birth_count + 16'd1;
      end else begin
        rt_l[idx] = l;
      end
    endfunction

    function void note_item(wsr_pkg::item_t it);
      wsr_pkg::result_t r;
      logic [1:0] st;
      logic [15:0] w, l;
      logic [16:0] sum;
      int d, n, base, best, k;
      bit found;
      d = int'(it.destination);
      n = int'(it.neighbor);
      st = wsr_pkg::StUnchanged;
      if (it.operation == wsr_pkg::OpLoad) begin
        link_ok[n] = 1;
        link_w[n] = it.link_width;
        link_l[n] = it.link_length;
      end else if (!link_ok[n]) begin
        st = wsr_pkg::StNoLink;
      end else begin
        w = (link_w[n] < it.path_width) ? link_w[n] : it.path_width;
        sum = {1'b0, it.path_length} + {1'b0, link_l[n]};
        l = sum[16] ? 16'hFFFF : sum[15:0];
        base = d * wsr_pkg::Nbrs;
        if (!fwd_ok[d]) begin
          fwd_ok[d] = 1;
          fwd_w[d] = w;
          fwd_l[d] = l;
          fwd_hop[d] = 4'(n);
          fwd_t[d] = it.event_time;
          if (cur_mode) remember(base + n, w, l);
          st = wsr_pkg::StChanged;
        end else if (!cur_mode) begin
          if (fwd_l[d] > l || (fwd_l[d] == l && fwd_w[d] < w)) begin
            fwd_w[d] = w;
            fwd_l[d] = l;
            fwd_hop[d] = 4'(n);
            fwd_t[d] = it.event_time;
            st = wsr_pkg::StChanged;
          end
        end else if (fwd_w[d] < w) begin
          fwd_w[d] = w;
          fwd_l[d] = l;
          fwd_hop[d] = 4'(n);
          fwd_t[d] = it.event_time;
          remember(base + n, w, l);
          st = wsr_pkg::StChanged;
        end else if (fwd_w[d] == w) begin
          remember(base + n, w, l);
          if (fwd_l[d] > l) begin
            fwd_l[d] = l;
            fwd_hop[d] = 4'(n);
            fwd_t[d] = it.event_time;
            st = wsr_pkg::StChanged;
          end else if (fwd_hop[d] == 4'(n)) begin
            // The next hop got no better: fall back to the oldest remembered
            // route that is at least as wide and strictly shorter.
            fwd_l[d] = l;
            fwd_t[d] = it.event_time;
            found = 0;
            best = 0;
            for (int j = 0; j < wsr_pkg::Nbrs; j++) begin
              k = base + j;
              if (rt_ok[k] && rt_w[k] >= fwd_w[d] && rt_l[k] < l) begin
                if (!found || rt_ord[k] < rt_ord[best]) begin
                  found = 1;
                  best = k;
                end
              end
            end
            if (found) begin
              fwd_w[d] = rt_w[best];
              fwd_l[d] = rt_l[best];
              fwd_hop[d] = 4'(best - base);
            end
            st = wsr_pkg::StChanged;
          end
        end
      end
      r.status = st;
      r.route_destination = it.destination;
      if (fwd_ok[d]) begin
        r.best_width = fwd_w[d];
        r.best_length = fwd_l[d];
        r.best_next_hop = fwd_hop[d];
        r.stable_time = fwd_t[d];
      end else begin
        r.best_width = '0;
        r.best_length = '0;
        r.best_next_hop = '0;
        r.stable_time = '0;
      end
      owed_results.push_back(r);
    endfunction

    function void check_result(wsr_pkg::result_t got);
      wsr_pkg::result_t exp;
      if (owed_results.size() == 0) begin
        $error("result with no transaction outstanding: %h", got);
        failures++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status expected %0d actual %0d", exp.status, got.status);
        failures++;
      end
      if (got.route_destination !== exp.route_destination) begin
        $error("route_destination expected %0d actual %0d",
               exp.route_destination, got.route_destination);
        failures++;
      end
      if (got.best_width !== exp.best_width) begin
        $error("best_width expected %0d actual %0d", exp.best_width, got.best_width);
        failures++;
      end
      if (got.best_length !== exp.best_length) begin
        $error("best_length expected %0d actual %0d", exp.best_length, got.best_length);
        failures++;
      end
      if (got.best_next_hop !== exp.best_next_hop) begin
        $error("best_next_hop expected %0d actual %0d",
               exp.best_next_hop, got.best_next_hop);
        failures++;
      end
      if (got.stable_time !== exp.stable_time) begin
        $error("stable_time expected %0d actual %0d", exp.stable_time, got.stable_time);
        failures++;
      end
    endfunction
  endclass

  // The clearing pass after reset is the longest stretch without a handshake.
  localparam int StallLimit = 5000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  wsr_pkg::item_t   item_i = '0;
  logic             busy_o;
  logic             mode_we_i = 1'b0;
  logic             mode_i = 1'b0;
  logic             done_o;
  wsr_pkg::result_t result_o;

  route_table_tracker tracker = new();
  int  idle_cycles = 0;
  bit  quiet_phase = 0;

  widest_shortest_route_update dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .item_i    (item_i),
    .busy_o    (busy_o),
    .mode_we_i (mode_we_i),
    .mode_i    (mode_i),
    .done_o    (done_o),
    .result_o  (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Results cannot be held off, so every strobe is checked at the edge that
  // accepts it. The watchdog counts edges at which nothing is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_result(result_o);
      if (done_o || (start_i && !busy_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("FAIL widest_shortest_route_update");
      $finish;
    end
  end

  // Issue one transaction: optional random gap, then hold start until the
  // block accepts it. The prediction is made at the accepting edge. Start
  // stays high after acceptance; busy_o keeps it from being taken again.
  task automatic send_item(wsr_pkg::item_t it);
    while (!quiet_phase && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    tracker.note_item(it);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Mode is only written with nothing outstanding.
  task automatic set_mode(logic m);
    drain();
    mode_we_i <= 1'b1;
    mode_i <= m;
    @(posedge clk_i);
    mode_we_i <= 1'b0;
    tracker.cur_mode = m;
  endtask

  function automatic wsr_pkg::item_t load_item(int n, logic [15:0] lw, logic [15:0] ll);
    wsr_pkg::item_t it;
    it = '0;
    it.operation = wsr_pkg::OpLoad;
    it.neighbor = 4'(n);
    it.destination = 6'($urandom_range(63));
    it.link_width = lw;
    it.link_length = ll;
    it.path_width = 16'($urandom);
    it.path_length = 16'($urandom);
    it.event_time = $urandom;
    return it;
  endfunction

  function automatic wsr_pkg::item_t adv_item(int n, int d, logic [15:0] pw,
                                              logic [15:0] pl, logic [31:0] t);
    wsr_pkg::item_t it;
    it = '0;
    it.operation = wsr_pkg::OpAdv;
    it.neighbor = 4'(n);
    it.destination = 6'(d);
    it.path_width = pw;
    it.path_length = pl;
    it.link_width = 16'($urandom);
    it.link_length = 16'($urandom);
    it.event_time = t;
    return it;
  endfunction

  // Random costs drawn from small values half of the time so that ties and
  // fallbacks occur often, with near-maximum and full-range values mixed in.
  function automatic logic [15:0] cost_value();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom_range(6));
    endcase
  endfunction

  initial begin
    wsr_pkg::item_t it;
    int n, d;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: unknown neighbor, loads at the extremes, saturation,
    // ties in mode 1 and a fallback after the next hop gets worse.
    quiet_phase = 1;
    send_item(adv_item(3, 63, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(load_item(0, 16'hFFFF, 16'hFFFF));
    send_item(load_item(15, 16'd0, 16'd0));
    send_item(load_item(1, 16'd100, 16'd5));
    send_item(load_item(2, 16'd100, 16'd1));
    send_item(adv_item(0, 0, 16'hFFFF, 16'hFFFF, 32'd1));
    send_item(adv_item(15, 0, 16'd0, 16'd0, 32'd2));
    send_item(adv_item(1, 0, 16'd50, 16'd0, 32'd3));
    send_item(adv_item(2, 0, 16'd60, 16'd4, 32'd4));
    send_item(adv_item(15, 63, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    set_mode(1'b1);
    send_item(adv_item(1, 5, 16'd80, 16'd10, 32'd10));
    send_item(adv_item(2, 5, 16'd80, 16'd20, 32'd11));
    send_item(adv_item(0, 5, 16'd80, 16'd30, 32'd12));
    send_item(adv_item(1, 5, 16'd80, 16'd50, 32'd13));
    send_item(adv_item(2, 5, 16'd90, 16'd50, 32'd14));
    send_item(adv_item(15, 5, 16'd90, 16'd0, 32'd15));
    send_item(adv_item(2, 5, 16'd90, 16'hFFFF, 32'd16));
    send_item(adv_item(0, 5, 16'hFFFF, 16'hFFFF, 32'd17));
    send_item(adv_item(0, 5, 16'hFFFF, 16'hFFF0, 32'd18));
    set_mode(1'b0);
    quiet_phase = 0;

    // Random part in phases that alternate the mode. Each phase sends a mix
    // of link loads (about one item in ten) and advertisements from random
    // neighbors, the advertisements mostly within destinations 0 to 7.
    for (int ph = 0; ph < 12; ph++) begin
      set_mode(ph[0]);
      quiet_phase = (ph == 5);
      for (int k = 0; k < 150; k++) begin
        n = $urandom_range(15);
        if ($urandom_range(9) == 0) begin
          send_item(load_item(n, cost_value(), cost_value()));
        end else begin
          d = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
          it = adv_item(n, d, cost_value(), cost_value(), $urandom);
          if ($urandom_range(7) == 0) it.operation = 1'($urandom_range(1));
          send_item(it);
        end
      end
    end
    quiet_phase = 0;

    drain();
    if (tracker.failures == 0 && tracker.owed_results.size() == 0) begin
      $display("PASS widest_shortest_route_update");
    end else begin
      $display("FAIL widest_shortest_route_update");
    end
    $finish;
  end
endmodule
